/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every edge out of reset.
`define AST_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle.
`define AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/wbps_pkg.sv */
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scan unit.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int unsigned PAT_BYTES = 16;              // bytes held by pattern regs
  localparam int unsigned PAT_W     = PAT_BYTES * 8;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN = 2'd2;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef logic [7:0]       byte_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic found;
    pos_t match_offset;
  } res_t;

endpackage

/* rtl/wildcard_byte_pattern_scan_unit.sv */
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan_unit
// Streams bytes through a row of window cells and reports the first match of
// a wildcard pattern per region, or a not-found word when the region ends.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   in      | input     | in_valid/in_stall  | data_byte, first/last_of_region
//   out     | output    | out_valid/out_stall| found, match_offset
//   cfg     | input     | cfg_wr_en          | cfg_index, cfg_wdata
//
// One byte per cycle while in_stall is low. The compare runs on the byte as it
// enters, so a result word is registered at the edge that accepts its byte.
// Reset (rst_n low, synchronous) empties the output buffer, clears position
// and match flag, and sets pattern_len to 1 with an all-wildcard pattern.
// Input stalls only when both output entries hold words, i.e. after the
// downstream side has stalled for at least two result words.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan_unit #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input bytes
  input  logic                              in_valid,
  output logic                              in_stall,
  input  wbps_pkg::byte_t                   in_data_byte,
  input  logic                              in_first_of_region,
  input  logic                              in_last_of_region,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output wbps_pkg::pos_t                    out_match_offset,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbps_pkg::CFG_W-1:0]        cfg_wdata
);
  import wbps_pkg::*;

  `include "assert_macros.svh"

  localparam len_t MAX_LEN = LEN_W'(MAX_PATTERN);

  // configuration registers
  logic [CFG_W-1:0] pattern_lo_r;
  logic [CFG_W-1:0] pattern_hi_r;
  len_t             pattern_len_r;
  logic [PAT_W-1:0] pattern;
  len_t             eff_len;

  // scan control
  pos_t position_r, position_nxt;
  logic already_found_r, already_found_nxt;
  logic in_accept;
  logic af_eff;      // match flag after a region start clears it
  logic work;        // byte is shifted into the window
  pos_t pos_base;
  logic all_hit;
  logic matched;
  logic emit;
  res_t res;
  res_t out_res;

  // cell row
  byte_t                  win  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_lo_r  <= '0;
      pattern_hi_r  <= '0;
      pattern_len_r <= len_t'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PATTERN_LO:  pattern_lo_r  <= cfg_wdata;
        REG_PATTERN_HI:  pattern_hi_r  <= cfg_wdata;
        REG_PATTERN_LEN: pattern_len_r <= cfg_wdata[LEN_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign pattern = {pattern_hi_r, pattern_lo_r};

  // zero length acts as one, long lengths clip to the window depth
  always_comb begin
    priority if (pattern_len_r == '0) begin
      eff_len = len_t'(1);
    end else if (pattern_len_r > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = pattern_len_r;
    end
  end

  // ---------------------------------------------------------------- cells
  assign in_accept = in_valid && !in_stall;
  assign af_eff    = in_first_of_region ? 1'b0 : already_found_r;
  assign work      = in_accept && !af_eff;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    byte_t din;
    if (k == 0) begin : g_head
      assign din = in_data_byte;
    end else begin : g_link
      assign din = win[k-1];
    end
    wbps_cell #(
      .IDX (k)
    ) u_cell (
      .clk      (clk),
      .shift_en (work),
      .first    (in_first_of_region),
      .din      (din),
      .pattern  (pattern),
      .eff_len  (eff_len),
      .dout     (win[k]),
      .hit      (hit[k])
    );
  end

  assign all_hit = &hit;

  // ---------------------------------------------------------------- position
  // saturating count of bytes taken in the region, including this one
  assign pos_base     = in_first_of_region ? '0 : position_r;
  assign position_nxt = (pos_base == POS_MAX) ? POS_MAX : pos_base + pos_t'(1);

  assign matched = (position_nxt >= pos_t'(eff_len)) && all_hit;
  assign emit    = work && (matched || in_last_of_region);

  always_comb begin
    res.found        = matched;
    res.match_offset = matched ? (position_nxt - pos_t'(eff_len)) : '0;
  end

  // once set, later bytes of the region are dropped until the next start
  assign already_found_nxt = af_eff || matched || in_last_of_region;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r      <= '0;
      already_found_r <= 1'b0;
    end else if (in_accept) begin
      already_found_r <= already_found_nxt;
      if (work) begin
        position_r <= position_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- output
  wbps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_res  (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_found        = out_res.found;
  assign out_match_offset = out_res.match_offset;

  // ---------------------------------------------------------------- checks
  `AST_SAME(a_notfound_zero, out_valid && !out_found, out_match_offset == '0, "not-found word carries an offset")
  `AST_NEXT(a_last_closes, in_accept && in_last_of_region, already_found_r, "region end did not close the region")
  `AST_SAME(a_offset_range, emit && matched, res.match_offset < position_nxt, "match offset beyond position")

endmodule

/* rtl/wbps_cell.sv */
// ----------------------------------------------------------------------------
// wbps_cell
// One window byte: shifts in from its neighbor and compares the byte it is
// about to hold against its pattern byte.
// ----------------------------------------------------------------------------
module wbps_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                 clk,
  input  logic                 shift_en,
  input  logic                 first,
  input  wbps_pkg::byte_t      din,
  input  logic [wbps_pkg::PAT_W-1:0] pattern,
  input  wbps_pkg::len_t       eff_len,
  output wbps_pkg::byte_t      dout,
  output logic                 hit
);
  import wbps_pkg::*;

  localparam len_t IDX_L = LEN_W'(IDX);

  byte_t      win_r;
  byte_t      win_nxt;
  logic       in_use;
  logic [3:0] sel;
  byte_t      pat;

  // start of region clears the rest of the window; cell 0 still takes the byte
  assign win_nxt = (first && (IDX != 0)) ? '0 : din;

  // pattern byte (n-1-IDX) lines up with this window slot
  assign in_use = IDX_L < eff_len;
  assign sel    = 4'(eff_len - IDX_L - len_t'(1));
  assign pat    = pattern[{sel, 3'b000} +: 8];
  assign hit    = !in_use || (pat == '0) || (pat == win_nxt);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r <= win_nxt;
    end
  end

  assign dout = win_r;

endmodule

/* rtl/wbps_out_buf.sv */
// ----------------------------------------------------------------------------
// wbps_out_buf
// Two-entry output buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
module wbps_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wbps_pkg::res_t  push_res,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output wbps_pkg::res_t  out_res
);
  import wbps_pkg::*;

  logic main_v_r, main_v_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic take;

  assign take = main_v_r && !out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    priority if (!main_v_r || take) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = push;
        skid_nxt   = push_res;
      end else begin
        main_v_nxt = push;
        main_nxt   = push_res;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_res;
    end else begin
      // output held and nothing new: both entries keep their words
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

endmodule
